/* hdl/stc_pkg.sv */
// Shared types, role codes and pitch-class helper for the sonority classifier.
// No dependencies; used by stc_ctrl, stc_dp and sonority_triad_role_classifier.
`timescale 1ns / 1ps

package stc_pkg;

    localparam int PCS = 12;
    localparam int NOTE_W = 7;
    localparam int PC_W = 4;
    localparam int CNT_SAT_W = 5;
    localparam int ROLE_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_THIRDS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIFTHS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIADS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLES = 2'd3;

    localparam logic [ROLE_W-1:0] ROLE_NONE  = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_ROOT  = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_UPPER = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_THIRD = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_FIFTH = 2'd3;

    typedef struct packed {
        logic store;
        logic analyze;
        logic issue;
        logic last;
        logic overflow;
    } stc_cmd_t;

    typedef struct packed {
        logic can_issue;
        logic rd_busy;
    } stc_stat_t;

    // note mod 12: reciprocal multiply (43/512) gives the exact quotient for 0..127
    function automatic logic [PC_W-1:0] pc_of(input logic [NOTE_W-1:0] note);
        logic [12:0] prod;
        logic [NOTE_W-1:0] rem;
        prod = {6'd0, note} * 13'd43;
        rem = note - NOTE_W'(7'(prod[12:9]) * 7'd12);
        return rem[PC_W-1:0];
    endfunction

endpackage

/* hdl/stc_ctrl.sv */
// Controller: sequences load, analysis and emission of one sonority.
// Depends on stc_pkg; drives stc_dp through stc_cmd_t.
`timescale 1ns / 1ps

module stc_ctrl
    import stc_pkg::*;
#(
    parameter int MAX_NOTES = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_last,
    output logic                              in_ready,
    input  stc_stat_t                         stat,
    output stc_cmd_t                          cmd,
    output logic [((MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1)-1:0] addr
);

    localparam int ADDR_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CNT_W = $clog2(MAX_NOTES + 1);

    localparam logic [1:0] S_LOAD    = 2'd0;
    localparam logic [1:0] S_ANALYZE = 2'd1;
    localparam logic [1:0] S_EMIT    = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] emit_reg, emit_next;
    logic             ovf_reg, ovf_next;
    logic             accept;

    assign in_ready = (state_reg == S_LOAD);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        emit_next = emit_reg;
        ovf_next = ovf_reg;
        cmd = '0;
        cmd.overflow = ovf_reg;
        addr = count_reg[ADDR_W-1:0];
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_NOTES))
                    begin
                        cmd.store = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        state_next = S_ANALYZE;
                    end
                end
            end
            S_ANALYZE:
            begin
                cmd.analyze = 1'b1;
                emit_next = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                addr = emit_reg[ADDR_W-1:0];
                if (emit_reg != count_reg)
                begin
                    if (stat.can_issue)
                    begin
                        cmd.issue = 1'b1;
                        cmd.last = (emit_reg == count_reg - 1'b1);
                        emit_next = emit_reg + 1'b1;
                    end
                end
                else if (!stat.rd_busy)
                begin
                    count_next = '0;
                    ovf_next = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            emit_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            emit_reg <= emit_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

/* hdl/stc_dp.sv */
// Datapath: note memory, pitch-class counts, set analysis, read stage, output register.
// Depends on stc_pkg; commanded by stc_ctrl.
`timescale 1ns / 1ps

module stc_dp
    import stc_pkg::*;
#(
    parameter int MAX_NOTES = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [0:0]                        cfg_data,
    input  logic [NOTE_W-1:0]                 note_in,
    input  stc_cmd_t                          cmd,
    input  logic [((MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1)-1:0] addr,
    output stc_stat_t                         stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        out_data,
    output logic                              out_last
);

    localparam int ADDR_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

    logic en3_reg, en5_reg, ent_reg, dbl_reg;

    logic [NOTE_W-1:0]    mem [MAX_NOTES];
    logic [CNT_SAT_W-1:0] cnt_reg [PCS];
    logic [PC_W-1:0]      pc_in;

    logic [PCS-1:0]  mask;
    logic [PC_W-1:0] c0, c1, c2, k, d, b, t, rank;
    logic            th_ok, fi_ok, tr_ok;
    logic [PC_W-1:0] th_root, th_top, fi_root, fi_top, tr_root, tr_third, tr_fifth;

    logic            th_ok_reg, fi_ok_reg, tr_ok_reg, matched_reg;
    logic [PC_W-1:0] th_root_reg, th_top_reg, fi_root_reg, fi_top_reg;
    logic [PC_W-1:0] tr_root_reg, tr_third_reg, tr_fifth_reg;
    logic [PCS-1:0]  single_reg;

    logic              rd_valid_reg, rd_last_reg;
    logic [NOTE_W-1:0] rd_data_reg;
    logic              out_load;
    logic [PC_W-1:0]   pc_rd;
    logic [ROLE_W-1:0] r3, r5, rt;

    logic       out_valid_reg, out_last_reg;
    logic [7:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en3_reg <= 1'b1;
            en5_reg <= 1'b1;
            ent_reg <= 1'b1;
            dbl_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THIRDS:  en3_reg <= cfg_data[0];
                CFG_FIFTHS:  en5_reg <= cfg_data[0];
                CFG_TRIADS:  ent_reg <= cfg_data[0];
                CFG_DOUBLES: dbl_reg <= cfg_data[0];
                default:     en3_reg <= en3_reg;
            endcase
        end
    end

    // note memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[addr] <= note_in;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[addr];
            rd_last_reg <= cmd.last;
        end
    end

    assign pc_in = pc_of(note_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PCS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.analyze)
        begin
            for (int i = 0; i < PCS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.store && (cnt_reg[pc_in] != {CNT_SAT_W{1'b1}}))
        begin
            cnt_reg[pc_in] <= cnt_reg[pc_in] + 1'b1;
        end
    end

    // sorted distinct classes via per-class rank
    always_comb
    begin
        c0 = '0;
        c1 = '0;
        c2 = '0;
        rank = '0;
        for (int i = 0; i < PCS; i++)
        begin
            mask[i] = (cnt_reg[i] != '0);
        end
        for (int i = 0; i < PCS; i++)
        begin
            rank = PC_W'($countones(mask & ~({PCS{1'b1}} << i)));
            if (mask[i] && rank == 4'd0) c0 = c0 | PC_W'(i);
            if (mask[i] && rank == 4'd1) c1 = c1 | PC_W'(i);
            if (mask[i] && rank == 4'd2) c2 = c2 | PC_W'(i);
        end
        k = PC_W'($countones(mask));
        d = c1 - c0;
        b = c1 - c0;
        t = c2 - c1;

        th_ok = 1'b0;
        th_root = c0;
        th_top = c1;
        if (k == 4'd2 && (d == 4'd3 || d == 4'd4))
        begin
            th_ok = 1'b1;
        end
        else if (k == 4'd2 && (d == 4'd8 || d == 4'd9))
        begin
            th_ok = 1'b1;
            th_root = c1;
            th_top = c0;
        end

        fi_ok = 1'b0;
        fi_root = c0;
        fi_top = c1;
        if (k == 4'd2 && (d == 4'd6 || d == 4'd7))
        begin
            fi_ok = 1'b1;
        end
        else if (k == 4'd2 && d == 4'd5)
        begin
            fi_ok = 1'b1;
            fi_root = c1;
            fi_top = c0;
        end

        tr_ok = 1'b0;
        tr_root = c0;
        tr_third = c1;
        tr_fifth = c2;
        if (k == 4'd3)
        begin
            if ((b == 4'd3 && t == 4'd4) || (b == 4'd4 && t == 4'd3) || (b == 4'd3 && t == 4'd3))
            begin
                tr_ok = 1'b1;
            end
            else if ((b == 4'd4 && t == 4'd5) || (b == 4'd3 && t == 4'd5)
                     || (b == 4'd3 && t == 4'd6))
            begin
                tr_ok = 1'b1;
                tr_root = c2;
                tr_third = c0;
                tr_fifth = c1;
            end
            else if ((b == 4'd5 && t == 4'd3) || (b == 4'd5 && t == 4'd4)
                     || (b == 4'd6 && t == 4'd3))
            begin
                tr_ok = 1'b1;
                tr_root = c1;
                tr_third = c2;
                tr_fifth = c0;
            end
        end
        th_ok = th_ok && en3_reg;
        fi_ok = fi_ok && en5_reg;
        tr_ok = tr_ok && ent_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_ok_reg <= 1'b0;
            fi_ok_reg <= 1'b0;
            tr_ok_reg <= 1'b0;
            matched_reg <= 1'b0;
        end
        else if (cmd.analyze)
        begin
            th_ok_reg <= th_ok;
            fi_ok_reg <= fi_ok;
            tr_ok_reg <= tr_ok;
            matched_reg <= th_ok || fi_ok || tr_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.analyze)
        begin
            th_root_reg <= th_root;
            th_top_reg <= th_top;
            fi_root_reg <= fi_root;
            fi_top_reg <= fi_top;
            tr_root_reg <= tr_root;
            tr_third_reg <= tr_third;
            tr_fifth_reg <= tr_fifth;
            for (int i = 0; i < PCS; i++)
            begin
                single_reg[i] <= (cnt_reg[i] == 5'd1);
            end
        end
    end

    // read stage to output register
    assign out_load = rd_valid_reg && (!out_valid_reg || out_ready);
    assign stat.can_issue = !rd_valid_reg || out_load;
    assign stat.rd_busy = rd_valid_reg;

    always_comb
    begin
        pc_rd = pc_of(rd_data_reg);
        r3 = ROLE_NONE;
        r5 = ROLE_NONE;
        rt = ROLE_NONE;
        if (th_ok_reg && pc_rd == th_root_reg) r3 = ROLE_ROOT;
        else if (th_ok_reg && pc_rd == th_top_reg) r3 = ROLE_UPPER;
        if (fi_ok_reg && pc_rd == fi_root_reg) r5 = ROLE_ROOT;
        else if (fi_ok_reg && pc_rd == fi_top_reg) r5 = ROLE_UPPER;
        if (tr_ok_reg && pc_rd == tr_root_reg) rt = ROLE_ROOT;
        else if (tr_ok_reg && pc_rd == tr_third_reg) rt = ROLE_THIRD;
        else if (tr_ok_reg && pc_rd == tr_fifth_reg) rt = ROLE_FIFTH;
        // a role held by one note means its class occurs once
        if (dbl_reg && single_reg[pc_rd])
        begin
            r3 = ROLE_NONE;
            r5 = ROLE_NONE;
            rt = ROLE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.issue || (rd_valid_reg && !out_load);
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {cmd.overflow, matched_reg, rt, r5, r3};
            out_last_reg <= rd_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

endmodule

/* hdl/sonority_triad_role_classifier.sv */
// Top level of the sonority triad role classifier.
// Depends on stc_pkg, stc_ctrl and stc_dp.
//
// Input stream: one note per transaction, tdata[6:0] note number, tlast on the
// final note of a sonority. Up to MAX_NOTES notes are stored; later notes are
// dropped and flag overflow. Output stream: one transaction per stored note in
// arrival order, tlast on the final one.
// After the last note is taken, the first result passes through the analysis
// state, the memory read stage and the output register.
// Throughput: notes load at one per cycle and results leave at one per cycle
// while the receiver is ready; the note memory serves loading and emission in
// turn, never both at once.
// Input tready is low from the last note until every read of the sonority has
// left the read stage; the final result may still wait in the output register
// while the next sonority loads. A stalled receiver holds the output register
// and stops further memory reads.
// Reset clears counts, state and the output valid, and restores the
// configuration defaults (all analyses on, doubles filter off).
`timescale 1ns / 1ps

module sonority_triad_role_classifier
    import stc_pkg::*;
#(
    parameter int MAX_NOTES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [0:0]            cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [6:0] note_number, [7] zero
    input  logic                  s_tlast,   // last_note
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [1:0] third_role, [3:2] fifth_role,
                                             // [5:4] triad_role, [6] sonority_matched,
                                             // [7] overflow
    output logic                  m_tlast    // last_result
);

    localparam int ADDR_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

    stc_cmd_t          cmd;
    stc_stat_t         stat;
    logic [ADDR_W-1:0] addr;

    stc_ctrl #(
        .MAX_NOTES(MAX_NOTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .addr     (addr)
    );

    stc_dp #(
        .MAX_NOTES(MAX_NOTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .note_in   (s_tdata[NOTE_W-1:0]),
        .cmd       (cmd),
        .addr      (addr),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.store && cmd.issue))
        else $error("memory written and read in the same cycle");

    a_issue_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> stat.can_issue)
        else $error("read issued while read stage is blocked");

    a_last_analyze: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (cmd.analyze && !s_tready))
        else $error("last note not followed by analysis");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.analyze |=> !s_tready)
        else $error("input accepted during emission");

endmodule

/* bench/stc_scoreboard_pkg.sv */
// Scoreboard for the sonority classifier bench: predicts per-note role transactions.
// Depends on stc_pkg; used by tb_top.
`timescale 1ns / 1ps

package stc_scoreboard_pkg;

    import stc_pkg::*;

    typedef struct packed {
        logic [ROLE_W-1:0] third_role;
        logic [ROLE_W-1:0] fifth_role;
        logic [ROLE_W-1:0] triad_role;
        logic              matched;
        logic              overflow;
        logic              last;
    } note_roles_t;

    class sonority_scoreboard;
        localparam int CAPACITY = 16;

        // bit i holds register i: thirds, fifths, triads, doubles_only
        bit [3:0]    regs = 4'b0111;
        logic [6:0]  held_notes[$];
        bit [11:0]   classes_present;
        bit          spilled;
        note_roles_t role_queue[$];
        int          errors;
        int          checked;
        int          chords;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, bit value);
            regs[idx] = value;
        endfunction

        function int pending();
            return role_queue.size();
        endfunction

        function void note_input(logic [6:0] note, bit last);
            int          cls[$];
            int          root[3];
            int          upper[3];
            int          cnt[3][4];
            logic [1:0]  role[3][CAPACITY];
            int          fifth_pc;
            int          n, d, b, t, pc, a, i;
            bit          hit;
            note_roles_t e;
            if (held_notes.size() < CAPACITY) begin
                held_notes = {held_notes, note};
                classes_present[int'(note) % 12] = 1'b1;
            end
            else begin
                spilled = 1'b1;
            end
            if (!last)
                return;

            for (i = 0; i < 12; i++)
                if (classes_present[i])
                    cls = {cls, i};
            // analysis index: 0 thirds, 1 fifths, 2 triads
            root = '{-1, -1, -1};
            upper = '{-1, -1, -1};
            fifth_pc = -1;
            if (cls.size() == 2) begin
                d = cls[1] - cls[0];
                if (d == 3 || d == 4) begin
                    root[0] = cls[0];
                    upper[0] = cls[1];
                end
                else if (d == 8 || d == 9) begin
                    root[0] = cls[1];
                    upper[0] = cls[0];
                end
                if (d == 6 || d == 7) begin
                    root[1] = cls[0];
                    upper[1] = cls[1];
                end
                else if (d == 5) begin
                    root[1] = cls[1];
                    upper[1] = cls[0];
                end
            end
            else if (cls.size() == 3) begin
                b = cls[1] - cls[0];
                t = cls[2] - cls[1];
                if ((b == 3 && t == 4) || (b == 4 && t == 3) || (b == 3 && t == 3)) begin
                    root[2] = cls[0];
                    upper[2] = cls[1];
                    fifth_pc = cls[2];
                end
                else if ((b == 4 && t == 5) || (b == 3 && t == 5) || (b == 3 && t == 6)) begin
                    root[2] = cls[2];
                    upper[2] = cls[0];
                    fifth_pc = cls[1];
                end
                else if ((b == 5 && t == 3) || (b == 5 && t == 4) || (b == 6 && t == 3)) begin
                    root[2] = cls[1];
                    upper[2] = cls[2];
                    fifth_pc = cls[0];
                end
            end
            if (!regs[CFG_THIRDS])
                root[0] = -1;
            if (!regs[CFG_FIFTHS])
                root[1] = -1;
            if (!regs[CFG_TRIADS])
                root[2] = -1;
            hit = root[0] >= 0 || root[1] >= 0 || root[2] >= 0;

            n = held_notes.size();
            cnt = '{default: 0};
            for (i = 0; i < n; i++) begin
                pc = int'(held_notes[i]) % 12;
                for (a = 0; a < 3; a++) begin
                    role[a][i] = ROLE_NONE;
                    if (root[a] >= 0) begin
                        if (pc == root[a])
                            role[a][i] = ROLE_ROOT;
                        else if (pc == upper[a])
                            role[a][i] = (a == 2) ? ROLE_THIRD : ROLE_UPPER;
                        else if (a == 2 && pc == fifth_pc)
                            role[a][i] = ROLE_FIFTH;
                    end
                    cnt[a][role[a][i]]++;
                end
            end
            if (regs[CFG_DOUBLES])
                for (i = 0; i < n; i++)
                    for (a = 0; a < 3; a++)
                        if (role[a][i] != ROLE_NONE && cnt[a][role[a][i]] == 1)
                            role[a][i] = ROLE_NONE;

            for (i = 0; i < n; i++) begin
                e.third_role = role[0][i];
                e.fifth_role = role[1][i];
                e.triad_role = role[2][i];
                e.matched = hit;
                e.overflow = spilled;
                e.last = (i == n - 1);
                role_queue = {role_queue, e};
            end
            held_notes.delete();
            classes_present = '0;
            spilled = 1'b0;
            chords++;
        endfunction

        function void compare(string field, logic [1:0] want, logic [1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [7:0] data, logic last);
            note_roles_t e;
            if (role_queue.size() == 0) begin
                $error("result transaction with nothing expected: tdata=%h tlast=%b", data, last);
                errors++;
                return;
            end
            e = role_queue.pop_front();
            checked++;
            compare("third_role", e.third_role, data[1:0]);
            compare("fifth_role", e.fifth_role, data[3:2]);
            compare("triad_role", e.triad_role, data[5:4]);
            compare("sonority_matched", 2'(e.matched), 2'(data[6]));
            compare("overflow", 2'(e.overflow), 2'(data[7]));
            compare("last_result", 2'(e.last), 2'(last));
        endfunction
    endclass

endpackage

/* bench/tb_top.sv */
// Top-level bench for sonority_triad_role_classifier: directed and random sonorities,
// random stalls on both streams, checked against stc_scoreboard_pkg.
// Depends on stc_pkg, stc_scoreboard_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

    import stc_pkg::*;
    import stc_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [0:0]           cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;   // [6:0] note_number, [7] zero
    logic                 s_tlast = 1'b0; // last_note
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;        // [1:0] third, [3:2] fifth, [5:4] triad,
                                          // [6] matched, [7] overflow
    logic                 m_tlast;        // last_result

    sonority_scoreboard sb = new();
    int send_idle = 30;
    int recv_idle = 79;
    int notes_sent;
    int settings_used;

    sonority_triad_role_classifier i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // result side: check accepted transactions, then pick next ready
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic send_note(input logic [6:0] note, input bit last);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, note};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(note, last);
        notes_sent++;
    endtask

    // registers change only with the block drained and idle
    task automatic apply_settings(input logic [3:0] bits);
        logic [CFG_IDX_W-1:0] reg_order[4];
        int r;
        reg_order = '{CFG_THIRDS, CFG_FIFTHS, CFG_TRIADS, CFG_DOUBLES};
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        for (r = 0; r < 4; r++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= reg_order[r];
            cfg_data <= bits[reg_order[r]];
            sb.write_reg(reg_order[r], bits[reg_order[r]]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random_chord();
        int pcs[$];
        int notes[$];
        int kind, root, k, n, i, j, tmp, pc;
        kind = $urandom_range(9);
        root = $urandom_range(11);
        case (kind)
            0, 1: pcs = {root, (root + $urandom_range(3, 4)) % 12};
            2, 3: pcs = {root, (root + $urandom_range(5, 7)) % 12};
            4, 5, 6:
            begin
                k = $urandom_range(2);  // major, minor, diminished
                pcs = {root, (root + (k == 0 ? 4 : 3)) % 12, (root + (k == 2 ? 6 : 7)) % 12};
            end
            7:
            begin
                // augmented, optionally with a seventh: no match with all classes present
                pcs = {root, (root + 4) % 12, (root + 8) % 12};
                if ($urandom_range(1))
                    pcs = {pcs, (root + 10) % 12};
            end
            default:
            begin
                k = $urandom_range(1, 5);
                for (i = 0; i < k; i++)
                    pcs = {pcs, int'($urandom_range(11))};
            end
        endcase
        k = $urandom_range(99);
        if (k < 80)
            n = pcs.size() + $urandom_range(3);
        else if (k < 92)
            n = $urandom_range(1, 8);
        else
            n = $urandom_range(14, 20);
        for (i = 0; i < n; i++)
        begin
            pc = (i < pcs.size()) ? pcs[i] : pcs[$urandom_range(pcs.size() - 1)];
            notes = {notes, int'(pc + 12 * $urandom_range(pc <= 7 ? 10 : 9))};
        end
        for (i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = notes[i];
            notes[i] = notes[j];
            notes[j] = tmp;
        end
        for (i = 0; i < n; i++)
            send_note(7'(notes[i]), i == n - 1);
    endtask

    initial
    begin
        logic [3:0] settings[8];
        int block, i, target;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        apply_settings(4'b0111);

        // extremes of the note range, single note, major triad
        send_note(7'd0, 1'b0);
        send_note(7'd127, 1'b1);
        send_note(7'd60, 1'b1);
        send_note(7'd60, 1'b0);
        send_note(7'd64, 1'b0);
        send_note(7'd67, 1'b1);
        // inverted third, inverted fifth
        send_note(7'd60, 1'b0);
        send_note(7'd68, 1'b1);
        send_note(7'd60, 1'b0);
        send_note(7'd65, 1'b1);
        // capacity exceeded, last note dropped
        for (i = 0; i < 17; i++)
            send_note(i % 2 ? 7'd67 : 7'd61, i == 16);

        settings = '{4'hF, 4'h0, 4'h8, 4'h7, 4'hA, 4'h5, 4'h0, 4'h0};
        settings[6] = 4'($urandom_range(15));
        settings[7] = 4'($urandom_range(15));
        for (block = 0; block < 8; block++)
        begin
            if (block == 3)
            begin
                send_idle = 79;
                recv_idle = 30;
            end
            else if (block == 6)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            apply_settings(settings[block]);
            target = notes_sent + 36;
            while (notes_sent < target)
                send_random_chord();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("summary: %0d notes in %0d sonorities, %0d results checked, %0d settings",
                 notes_sent, sb.chords, sb.checked, settings_used);
        $display("summary: %0d mismatches", sb.errors);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
